### hdl/mono_lcd_readout_with_crc_macros.svh
// assertion macros for the mono lcd readout block
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef MONO_LCD_READOUT_WITH_CRC_MACROS_SVH
`define MONO_LCD_READOUT_WITH_CRC_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mlcd_pkg.sv
// shared types, constants and crc function for the mono lcd readout
// no dependencies
package mlcd_pkg;

    localparam int unsigned COLOR_W = 32;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIX_CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [PIX_CNT_W-1:0] PIX_LAST = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_COLOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 2'd2;

    localparam logic [COLOR_W-1:0] ON_COLOR_RST  = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] OFF_COLOR_RST = 32'hFFFF_FFFF;

    // one classified byte as it waits for expansion
    typedef struct packed {
        logic [BYTE_W-1:0] lcd_byte;
        logic              frame_last;
        logic              disp_on;
        logic [CRC_W-1:0]  crc_report;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // reflected crc-32 over one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/mlcd_if.sv
// valid/ready channel interfaces for lcd bytes in and pixels out
// depends on mlcd_pkg
interface mlcd_in_if;
    logic                          valid;
    logic                          ready;
    logic [mlcd_pkg::BYTE_W-1:0]   lcd_byte;
    logic                          frame_last;

    modport source (output valid, output lcd_byte, output frame_last, input ready);
    modport sink   (input valid, input lcd_byte, input frame_last, output ready);
endinterface

interface mlcd_out_if;
    logic                          valid;
    logic                          ready;
    logic [mlcd_pkg::COLOR_W-1:0]  pixel_color;
    logic                          byte_done;
    logic                          frame_done;
    logic [mlcd_pkg::CRC_W-1:0]    frame_crc;
    logic                          screen_off;
    logic                          calc_busy;

    modport source (output valid, output pixel_color, output byte_done, output frame_done,
                    output frame_crc, output screen_off, output calc_busy, input ready);
    modport sink   (input valid, input pixel_color, input byte_done, input frame_done,
                    input frame_crc, input screen_off, input calc_busy, output ready);
endinterface

### hdl/mlcd_fifo.sv
// two-entry queue of classified bytes between front and back
// depends on mlcd_pkg
module mlcd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlcd_pkg::t_item i_wr_item,
    input  logic            i_pop,
    output mlcd_pkg::t_item o_rd_item,
    output mlcd_pkg::t_q_stat o_stat
);
    mlcd_pkg::t_item r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

    // pointers and fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= n_count;
        end
    end

    assign o_rd_item    = r_mem[r_rptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
endmodule

### hdl/mlcd_front.sv
// front end: accepts lcd bytes, runs the frame crc, queues classified bytes
// depends on mlcd_pkg, mlcd_if
module mlcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlcd_in_if.sink           in_ch,
    input  logic              i_display_on,
    input  mlcd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output mlcd_pkg::t_item   o_item
);
    logic [mlcd_pkg::CRC_W-1:0] r_crc;
    logic [mlcd_pkg::CRC_W-1:0] crc_new;

    assign in_ch.ready = !i_q_stat.full;
    assign o_push      = in_ch.valid && !i_q_stat.full;

    assign crc_new = mlcd_pkg::crc_byte(r_crc, in_ch.lcd_byte);

    // classified byte for the back end
    always_comb begin
        o_item.lcd_byte   = in_ch.lcd_byte;
        o_item.frame_last = in_ch.frame_last;
        o_item.disp_on    = i_display_on;
        o_item.crc_report = i_display_on ? ~crc_new : mlcd_pkg::CRC_INIT;
    end

    // running crc, restarts after the last byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mlcd_pkg::CRC_INIT;
        end else if (o_push) begin
            r_crc <= in_ch.frame_last ? mlcd_pkg::CRC_INIT : crc_new;
        end
    end
endmodule

### hdl/mlcd_back.sv
// back end: expands each queued byte into eight pixels, one per cycle while the receiver is ready
// depends on mlcd_pkg, mlcd_if
module mlcd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mlcd_pkg::COLOR_W-1:0]  i_on_color,
    input  logic [mlcd_pkg::COLOR_W-1:0]  i_off_color,
    input  mlcd_pkg::t_q_stat             i_q_stat,
    input  mlcd_pkg::t_item               i_item,
    output logic                          o_pop,
    mlcd_out_if.source                    out_ch
);
    mlcd_pkg::t_item                  r_item;
    logic                             r_busy;
    logic [mlcd_pkg::PIX_CNT_W-1:0]   r_cnt;

    logic                             r_ovalid;
    logic [mlcd_pkg::COLOR_W-1:0]     r_pixel_color;
    logic                             r_byte_done;
    logic                             r_frame_done;
    logic [mlcd_pkg::CRC_W-1:0]       r_frame_crc;
    logic                             r_screen_off;
    logic                             r_calc_busy;

    logic advance;
    logic pix_last;
    logic pix_set;
    logic fin;

    assign advance  = !r_ovalid || out_ch.ready;
    assign pix_last = (r_cnt == mlcd_pkg::PIX_LAST);
    assign pix_set  = r_item.lcd_byte[mlcd_pkg::PIX_LAST - r_cnt];
    assign fin      = r_item.frame_last && pix_last;

    // take the next byte when idle or on the eighth pixel
    assign o_pop = advance && !i_q_stat.empty && (!r_busy || pix_last);

    // working byte and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (advance) begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (pix_last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (advance) begin
            r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_pixel_color <= (r_item.disp_on && pix_set) ? i_on_color : i_off_color;
            r_byte_done   <= pix_last;
            r_frame_done  <= fin;
            r_frame_crc   <= fin ? r_item.crc_report : '0;
            r_screen_off  <= fin && !r_item.disp_on;
            r_calc_busy   <= fin && r_item.lcd_byte[0];
        end
    end

    assign out_ch.valid       = r_ovalid;
    assign out_ch.pixel_color = r_pixel_color;
    assign out_ch.byte_done   = r_byte_done;
    assign out_ch.frame_done  = r_frame_done;
    assign out_ch.frame_crc   = r_frame_crc;
    assign out_ch.screen_off  = r_screen_off;
    assign out_ch.calc_busy   = r_calc_busy;
endmodule

### hdl/mono_lcd_readout_with_crc.sv
// mono lcd readout: 1bpp bytes in, eight 32-bit pixels out per byte, frame crc-32
// path: an accepted byte goes from the queue into the working byte register, its pixels into the output register
// throughput: one pixel per cycle while the receiver is ready, paced by the pixel counter
// a two-entry queue lets a byte be accepted while the previous one is still expanding
// reset (synchronous, active low): crc to all ones, queue and output empty, registers to defaults
`include "mono_lcd_readout_with_crc_macros.svh"

module mono_lcd_readout_with_crc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mlcd_in_if.sink                         i_pix_in,
    mlcd_out_if.source                      o_pix_out,
    input  logic                            i_cfg_we,
    input  logic [mlcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mlcd_pkg::COLOR_W-1:0]    i_cfg_data
);
    logic [mlcd_pkg::COLOR_W-1:0] r_on_color;
    logic [mlcd_pkg::COLOR_W-1:0] r_off_color;
    logic                         r_display_on;

    mlcd_pkg::t_q_stat q_stat;
    mlcd_pkg::t_item   wr_item;
    mlcd_pkg::t_item   rd_item;
    logic              push;
    logic              pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_color   <= mlcd_pkg::ON_COLOR_RST;
            r_off_color  <= mlcd_pkg::OFF_COLOR_RST;
            r_display_on <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlcd_pkg::CFG_ON_COLOR:   r_on_color   <= i_cfg_data;
                mlcd_pkg::CFG_OFF_COLOR:  r_off_color  <= i_cfg_data;
                mlcd_pkg::CFG_DISPLAY_ON: r_display_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mlcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (i_pix_in),
        .i_display_on (r_display_on),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_item       (wr_item)
    );

    mlcd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_item (wr_item),
        .i_pop     (pop),
        .o_rd_item (rd_item),
        .o_stat    (q_stat)
    );

    mlcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_on_color  (r_on_color),
        .i_off_color (r_off_color),
        .i_q_stat    (q_stat),
        .i_item      (rd_item),
        .o_pop       (pop),
        .out_ch      (o_pix_out)
    );

    // checks
    `MLCD_ASSERT_IMPLY(a_frame_on_byte, o_pix_out.valid && o_pix_out.frame_done, o_pix_out.byte_done, "frame_done without byte_done")
    `MLCD_ASSERT_IMPLY(a_side_zero, o_pix_out.valid && !o_pix_out.frame_done, o_pix_out.frame_crc == '0 && !o_pix_out.screen_off && !o_pix_out.calc_busy, "frame fields set outside frame end")
    `MLCD_ASSERT_IMPLY(a_blank_crc, o_pix_out.valid && o_pix_out.frame_done && o_pix_out.screen_off, o_pix_out.frame_crc == mlcd_pkg::CRC_INIT, "blank frame crc not all ones")
    `MLCD_ASSERT_NEXT(a_byte_start, o_pix_out.valid && o_pix_out.ready && o_pix_out.byte_done, !(o_pix_out.valid && o_pix_out.byte_done), "byte_done on two pixels in a row")
endmodule

### tb/sv/tb_mono_lcd_readout_with_crc.sv
`timescale 1ns / 1ps
// self-checking testbench for mono_lcd_readout_with_crc: directed table, then random frames
// depends on mlcd_pkg and the mlcd_in_if / mlcd_out_if channel interfaces
module tb_mono_lcd_readout_with_crc;

    localparam logic [mlcd_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;   // index past the register list
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_SLACK = 4;
    localparam int unsigned WDOG_LIMIT  = 1000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_BYTES = 22;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one row of the directed table: a byte transaction or a register write
    typedef struct packed {
        t_row_kind                          kind;
        logic [mlcd_pkg::CFG_IDX_W-1:0]     idx;
        logic [mlcd_pkg::COLOR_W-1:0]       data;
        logic                               last;
        logic                               fixed;
        logic [mlcd_pkg::CRC_W-1:0]         crc;
    } t_dir_row;

    // one expected pixel transaction
    typedef struct packed {
        logic [mlcd_pkg::COLOR_W-1:0] color;
        logic                         byte_done;
        logic                         frame_done;
        logic [mlcd_pkg::CRC_W-1:0]   crc;
        logic                         scr_off;
        logic                         busy;
    } t_pixel_exp;

    localparam int unsigned DIR_ROWS = 30;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0000, 1'b1, 1'b1, 32'hD202_EF8D},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_00FF, 1'b1, 1'b1, 32'hFF00_0000},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0031, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0032, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0033, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0034, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0035, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0036, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0037, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0038, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0039, 1'b1, 1'b1, 32'hCBF4_3926},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_00A5, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_005A, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_ON_COLOR,   32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_OFF_COLOR,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0080, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_ON_COLOR,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_OFF_COLOR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_007E, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_DISPLAY_ON, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0055, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_00AA, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_CFG,  mlcd_pkg::CFG_DISPLAY_ON, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_000F, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_DISPLAY_ON, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_00F0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  mlcd_pkg::CFG_DISPLAY_ON, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG,  CFG_NONE,                 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CFG_NONE,                 32'h0000_003C, 1'b1, 1'b0, 32'h0}
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [mlcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [mlcd_pkg::COLOR_W-1:0]        i_cfg_data;

    mlcd_in_if  in_ch ();
    mlcd_out_if out_ch ();

    mono_lcd_readout_with_crc dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_in   (in_ch),
        .o_pix_out  (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state: registers and running crc
    logic [mlcd_pkg::COLOR_W-1:0] lcd_on_color;
    logic [mlcd_pkg::COLOR_W-1:0] lcd_off_color;
    logic                         lcd_disp_on;
    logic [mlcd_pkg::CRC_W-1:0]   lcd_crc;

    t_pixel_exp pix_expect_q [$];

    int unsigned fail_cnt;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned blank_frames;
    int unsigned pixels_seen;
    int unsigned reg_writes;
    int unsigned holds_done;
    int unsigned stall_cycles;
    int unsigned burst_left;
    bit          hold_req;

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // reflected crc-32, one data bit at a time from the lsb
    function automatic logic [mlcd_pkg::CRC_W-1:0] crc_step(
            input logic [mlcd_pkg::CRC_W-1:0]  crc,
            input logic [mlcd_pkg::BYTE_W-1:0] b);
        logic [mlcd_pkg::CRC_W-1:0] c;
        logic                       fb;
        c = crc;
        for (int i = 0; i < mlcd_pkg::BYTE_W; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ mlcd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // expand one accepted byte into its eight expected pixels
    function automatic void predict_byte(input logic [mlcd_pkg::BYTE_W-1:0] b,
                                         input logic last, input logic fixed,
                                         input logic [mlcd_pkg::CRC_W-1:0] fixed_crc);
        logic [mlcd_pkg::CRC_W-1:0] report;
        t_pixel_exp                 px;
        report  = '0;
        lcd_crc = crc_step(lcd_crc, b);
        if (last) begin
            report = lcd_disp_on ? ~lcd_crc : mlcd_pkg::CRC_INIT;
            if (fixed) report = fixed_crc;
            lcd_crc = mlcd_pkg::CRC_INIT;
            frames_sent++;
            if (!lcd_disp_on) blank_frames++;
        end
        for (int k = 0; k < mlcd_pkg::BYTE_W; k++) begin
            px.color      = (lcd_disp_on && b[mlcd_pkg::BYTE_W-1-k]) ? lcd_on_color
                                                                     : lcd_off_color;
            px.byte_done  = (k == mlcd_pkg::BYTE_W - 1);
            px.frame_done = last && (k == mlcd_pkg::BYTE_W - 1);
            px.crc        = px.frame_done ? report : '0;
            px.scr_off    = px.frame_done && !lcd_disp_on;
            px.busy       = px.frame_done && b[0];
            pix_expect_q.push_back(px);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // offer one byte and wait for the transaction
    task automatic push_item(input logic [mlcd_pkg::BYTE_W-1:0] b, input logic last,
                             input logic fixed, input logic [mlcd_pkg::CRC_W-1:0] fixed_crc);
        in_ch.valid      <= 1'b1;
        in_ch.lcd_byte   <= b;
        in_ch.frame_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(b, last, fixed, fixed_crc);
        bytes_sent++;
    endtask

    // bursty sender: random gap before each burst
    task automatic send_paced(input logic [mlcd_pkg::BYTE_W-1:0] b, input logic last,
                              input int unsigned max_gap);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        push_item(b, last, 1'b0, '0);
        burst_left--;
    endtask

    task automatic write_reg(input logic [mlcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mlcd_pkg::COLOR_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            mlcd_pkg::CFG_ON_COLOR:   lcd_on_color  = val;
            mlcd_pkg::CFG_OFF_COLOR:  lcd_off_color = val;
            mlcd_pkg::CFG_DISPLAY_ON: lcd_disp_on   = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // stop offering and let every expected pixel come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pix_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [mlcd_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mlcd_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // output check against the oldest expectation
    always @(posedge i_clk) begin : pixel_check
        t_pixel_exp want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            pixels_seen++;
            if (pix_expect_q.size() == 0) begin
                $error("pixel transaction with nothing expected: color %h", out_ch.pixel_color);
                fail_cnt++;
            end else begin
                want = pix_expect_q.pop_front();
                check_field("pixel_color", want.color, out_ch.pixel_color);
                check_field("byte_done", want.byte_done, out_ch.byte_done);
                check_field("frame_done", want.frame_done, out_ch.frame_done);
                check_field("frame_crc", want.crc, out_ch.frame_crc);
                check_field("screen_off", want.scr_off, out_ch.screen_off);
                check_field("calc_busy", want.busy, out_ch.calc_busy);
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: stretches of always-ready, random and periodic stalls, plus long hold-offs
    initial begin : rx_pace
        int unsigned mode;
        int unsigned span;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(8, 40);
                for (int k = 0; k < span && !hold_req; k++) begin
                    case (mode)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= $urandom_range(0, 1);
                        default: out_ch.ready <= (k % 5 != 2) && (k % 5 != 3);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // main sequence
    initial begin : stim
        t_row_kind                    prev_kind;
        int unsigned                  max_gap;
        int unsigned                  frame_left;
        logic [mlcd_pkg::COLOR_W-1:0] dval;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.lcd_byte   <= '0;
        in_ch.frame_last <= 1'b0;
        lcd_on_color  = mlcd_pkg::ON_COLOR_RST;
        lcd_off_color = mlcd_pkg::OFF_COLOR_RST;
        lcd_disp_on   = 1'b1;
        lcd_crc       = mlcd_pkg::CRC_INIT;
        hold_req      = 1'b0;
        burst_left    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        prev_kind = ROW_ITEM;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].kind == ROW_CFG) begin
                if (prev_kind == ROW_ITEM) wait_drained();
                write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
            end else begin
                if (prev_kind == ROW_CFG) i_cfg_we <= 1'b0;
                push_item(DIR_TAB[r].data[mlcd_pkg::BYTE_W-1:0], DIR_TAB[r].last,
                          DIR_TAB[r].fixed, DIR_TAB[r].crc);
            end
            prev_kind = DIR_TAB[r].kind;
        end
        wait_drained();

        // random phases, new register settings between them
        frame_left = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(mlcd_pkg::CFG_ON_COLOR, pick_color());
            write_reg(mlcd_pkg::CFG_OFF_COLOR, pick_color());
            dval    = $urandom;
            dval[0] = ($urandom_range(0, 3) != 0);
            write_reg(mlcd_pkg::CFG_DISPLAY_ON, dval);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_NONE, $urandom);
            i_cfg_we <= 1'b0;
            max_gap    = (ph == 1) ? 0 : $urandom_range(1, 6);
            burst_left = 0;
            for (int n = 0; n < PHASE_BYTES; n++) begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                             : $urandom_range(1, 6);
                // long receiver hold-off while bytes keep coming
                if (ph == 2 && n == 6) hold_req = 1'b1;
                // sender pause until the block has emptied
                if (ph == 3 && n == 12) begin
                    wait_drained();
                    burst_left = 0;
                end
                send_paced(pick_byte(), frame_left == 1, max_gap);
                frame_left--;
            end
            wait_drained();
        end

        // close any open frame
        if (frame_left != 0) begin
            push_item(pick_byte(), 1'b1, 1'b0, '0);
            wait_drained();
        end
        repeat (10) @(posedge i_clk);

        $display("run covered %0d bytes in %0d frames (%0d blank), %0d pixels checked",
                 bytes_sent, frames_sent, blank_frames, pixels_seen);
        $display("%0d register writes, %0d receiver hold-offs", reg_writes, holds_done);
        if (fail_cnt == 0 && pix_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pix_expect_q.size() != 0)
                $error("%0d expected pixels never arrived", pix_expect_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
